// ===== design/huffman_code_builder_unit_macros.svh =====
// Assertion macros used by the Huffman code builder datapath.
// Depends on nothing; files that assert include it by its bare name.
`ifndef HUFFMAN_CODE_BUILDER_UNIT_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked by i_clk and disabled in reset.
`define HCB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcb assertion failed");
// Next-cycle implication, clocked by i_clk and disabled in reset.
`define HCB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcb assertion failed");
`else
`define HCB_ASSERT_IMP(label, ante, cons)
`define HCB_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== design/hcb_pkg.sv =====
// Types and fixed field widths of the Huffman code builder.
// Used by the controller, the datapath and the top level.
package hcb_pkg;

    localparam int SYM_W   = 5;
    localparam int CODE_W  = 31;
    localparam int LEN_W   = 5;
    localparam int TOTAL_W = 26;
    localparam int OUT_DW  = 72;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic merge_init;
        logic scan_init;
        logic scan_run;
        logic write_a;
        logic write_b;
        logic write_k;
        logic walk_init;
        logic leaf_issue;
        logic leaf_capture;
        logic step_issue;
        logic step_capture;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic merges_done;
        logic scan_done;
        logic up_zero;
        logic out_free;
        logic last_sym;
    } t_stat;

endpackage

// ===== design/hcb_ctrl.sv =====
// Controller state machine of the Huffman code builder.
// Depends on hcb_pkg for the command and status structs.
module hcb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  hcb_pkg::t_stat i_stat,
    output hcb_pkg::t_cmd  o_cmd,
    output logic          o_in_ready
);
    import hcb_pkg::*;

    localparam logic [3:0] S_LOAD         = 4'd0;
    localparam logic [3:0] S_MERGE_INIT   = 4'd1;
    localparam logic [3:0] S_MERGE_CHECK  = 4'd2;
    localparam logic [3:0] S_SCAN         = 4'd3;
    localparam logic [3:0] S_WRITE_A      = 4'd4;
    localparam logic [3:0] S_WRITE_B      = 4'd5;
    localparam logic [3:0] S_WRITE_K      = 4'd6;
    localparam logic [3:0] S_LEAF_ISSUE   = 4'd7;
    localparam logic [3:0] S_LEAF_CAPTURE = 4'd8;
    localparam logic [3:0] S_STEP_CHECK   = 4'd9;
    localparam logic [3:0] S_STEP_CAPTURE = 4'd10;
    localparam logic [3:0] S_EMIT         = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    if (i_in_last) begin
                        n_state = S_MERGE_INIT;
                    end
                end
            end
            S_MERGE_INIT: begin
                w_cmd.merge_init = 1'b1;
                n_state          = S_MERGE_CHECK;
            end
            S_MERGE_CHECK: begin
                if (i_stat.merges_done) begin
                    w_cmd.walk_init = 1'b1;
                    n_state         = S_LEAF_ISSUE;
                end else begin
                    w_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_WRITE_A;
                end else begin
                    w_cmd.scan_run = 1'b1;
                end
            end
            S_WRITE_A: begin
                w_cmd.write_a = 1'b1;
                n_state       = S_WRITE_B;
            end
            S_WRITE_B: begin
                w_cmd.write_b = 1'b1;
                n_state       = S_WRITE_K;
            end
            S_WRITE_K: begin
                w_cmd.write_k = 1'b1;
                n_state       = S_MERGE_CHECK;
            end
            S_LEAF_ISSUE: begin
                w_cmd.leaf_issue = 1'b1;
                n_state          = S_LEAF_CAPTURE;
            end
            S_LEAF_CAPTURE: begin
                w_cmd.leaf_capture = 1'b1;
                n_state            = S_STEP_CHECK;
            end
            S_STEP_CHECK: begin
                if (i_stat.up_zero) begin
                    n_state = S_EMIT;
                end else begin
                    w_cmd.step_issue = 1'b1;
                    n_state          = S_STEP_CAPTURE;
                end
            end
            S_STEP_CAPTURE: begin
                w_cmd.step_capture = 1'b1;
                n_state            = S_STEP_CHECK;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    w_cmd.emit = 1'b1;
                    n_state    = i_stat.last_sym ? S_LOAD : S_LEAF_ISSUE;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = w_cmd;
    assign o_in_ready = (r_state == S_LOAD);

endmodule

// ===== design/hcb_datapath.sv =====
// Datapath of the Huffman code builder: node store, pick scan, code walk, result register.
// Depends on hcb_pkg and on huffman_code_builder_unit_macros.svh for its assertions.
`include "huffman_code_builder_unit_macros.svh"
module hcb_datapath #(
    parameter int MAX_SYMBOLS = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hcb_pkg::t_cmd                i_cmd,
    input  logic [WEIGHT_BITS-1:0]       i_weight,
    input  logic                         i_out_ready,
    output hcb_pkg::t_stat               o_stat,
    output logic                         o_out_valid,
    output logic [hcb_pkg::SYM_W-1:0]    o_out_sym,
    output logic [hcb_pkg::CODE_W-1:0]   o_out_code,
    output logic [hcb_pkg::LEN_W-1:0]    o_out_len,
    output logic [hcb_pkg::TOTAL_W-1:0]  o_out_total,
    output logic                         o_out_last
);
    import hcb_pkg::*;

    localparam int NODES = 2 * MAX_SYMBOLS;
    localparam int NW    = $clog2(NODES);
    localparam int KW    = $clog2(NODES + 1);
    localparam int LW    = $clog2(MAX_SYMBOLS + 1);
    localparam int WW    = WEIGHT_BITS + $clog2(MAX_SYMBOLS);
    localparam int PW    = WEIGHT_BITS + LW;

    // Node store: weights, parent links and left-child links.
    logic [WW-1:0] m_weight [NODES];
    logic [NW-1:0] m_parent [NODES];
    logic [NW-1:0] m_left   [NODES];

    logic [NW-1:0] w_rd_addr;
    logic          w_wt_we;
    logic [NW-1:0] w_wt_addr;
    logic [WW-1:0] w_wt_data;
    logic          w_par_we;
    logic [NW-1:0] w_par_addr;
    logic [NW-1:0] w_par_data;
    logic          w_left_we;
    logic [WW-1:0] r_wq;
    logic [NW-1:0] r_pq;
    logic [NW-1:0] r_lq;

    // Counters.
    logic [LW-1:0] r_n;
    logic [KW-1:0] r_k;
    logic [KW-1:0] r_i;
    logic [LW-1:0] r_s;

    // Pick scan.
    logic          r_pv;
    logic [NW-1:0] r_pidx;
    logic [1:0]    r_cnt;
    logic [NW-1:0] r_a;
    logic [NW-1:0] r_b;
    logic [WW-1:0] r_wa;
    logic [WW-1:0] r_wb;

    // Code walk.
    logic [NW-1:0]          r_up;
    logic [NW-1:0]          r_child;
    logic [LW-1:0]          r_len;
    logic [CODE_W-1:0]      r_code;
    logic [WEIGHT_BITS-1:0] r_ws;
    logic [TOTAL_W-1:0]     r_wpl;

    // Result register.
    logic               r_out_vld;
    logic [SYM_W-1:0]   r_out_sym;
    logic [CODE_W-1:0]  r_out_code;
    logic [LEN_W-1:0]   r_out_len;
    logic [TOTAL_W-1:0] r_out_tot;
    logic               r_out_last;

    logic               w_room;
    logic               w_last_sym;
    logic [PW-1:0]      w_prod;
    logic [TOTAL_W-1:0] w_tot;

    assign w_room     = r_n < LW'(MAX_SYMBOLS);
    assign w_last_sym = (r_s == r_n);
    assign w_prod     = {{LW{1'b0}}, r_ws} * {{WEIGHT_BITS{1'b0}}, r_len};
    assign w_tot      = r_wpl + TOTAL_W'(w_prod);

    // Read address and write ports of the node store.
    always_comb begin
        w_rd_addr  = r_i[NW-1:0];
        w_wt_we    = 1'b0;
        w_wt_addr  = r_k[NW-1:0];
        w_wt_data  = r_wa + r_wb;
        w_par_we   = 1'b0;
        w_par_addr = r_k[NW-1:0];
        w_par_data = '0;
        w_left_we  = 1'b0;
        if (i_cmd.leaf_issue) begin
            w_rd_addr = NW'(r_s);
        end else if (i_cmd.step_issue) begin
            w_rd_addr = r_up;
        end
        if (i_cmd.load && w_room) begin
            w_wt_we    = 1'b1;
            w_wt_addr  = NW'(r_n + 1'b1);
            w_wt_data  = WW'(i_weight);
            w_par_we   = 1'b1;
            w_par_addr = NW'(r_n + 1'b1);
        end
        if (i_cmd.write_a) begin
            w_wt_we    = 1'b1;
            w_par_we   = 1'b1;
            w_par_addr = r_a;
            w_par_data = r_k[NW-1:0];
            w_left_we  = 1'b1;
        end
        if (i_cmd.write_b) begin
            w_par_we   = 1'b1;
            w_par_addr = r_b;
            w_par_data = r_k[NW-1:0];
        end
        if (i_cmd.write_k) begin
            w_par_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wt_we) begin
            m_weight[w_wt_addr] <= w_wt_data;
        end
        if (w_par_we) begin
            m_parent[w_par_addr] <= w_par_data;
        end
        if (w_left_we) begin
            m_left[r_k[NW-1:0]] <= r_a;
        end
        r_wq <= m_weight[w_rd_addr];
        r_pq <= m_parent[w_rd_addr];
        r_lq <= m_left[w_rd_addr];
    end

    // Counters and the result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n       <= '0;
            r_k       <= '0;
            r_i       <= '0;
            r_s       <= '0;
            r_pv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load && w_room) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.merge_init) begin
                r_k <= KW'(r_n) + 1'b1;
            end
            if (i_cmd.write_k) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_i  <= KW'(1);
                r_pv <= 1'b0;
            end else if (i_cmd.scan_run && (r_i < r_k)) begin
                r_i  <= r_i + 1'b1;
                r_pv <= 1'b1;
            end else begin
                r_pv <= 1'b0;
            end
            if (i_cmd.walk_init) begin
                r_s <= LW'(1);
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
                if (w_last_sym) begin
                    r_n <= '0;
                end else begin
                    r_s <= r_s + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // The two lightest unmerged nodes; ties keep the lower index first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_cnt <= 2'd0;
        end else if (r_pv && (r_pq == '0)) begin
            case (r_cnt)
                2'd0: begin
                    r_a   <= r_pidx;
                    r_wa  <= r_wq;
                    r_cnt <= 2'd1;
                end
                2'd1: begin
                    r_cnt <= 2'd2;
                    if (r_wa > r_wq) begin
                        r_a  <= r_pidx;
                        r_wa <= r_wq;
                        r_b  <= r_a;
                        r_wb <= r_wa;
                    end else begin
                        r_b  <= r_pidx;
                        r_wb <= r_wq;
                    end
                end
                default: begin
                    if (r_wq < r_wa) begin
                        r_a  <= r_pidx;
                        r_wa <= r_wq;
                        r_b  <= r_a;
                        r_wb <= r_wa;
                    end else if (r_wq < r_wb) begin
                        r_b  <= r_pidx;
                        r_wb <= r_wq;
                    end
                end
            endcase
        end
        if (i_cmd.scan_run) begin
            r_pidx <= r_i[NW-1:0];
        end
    end

    // Walk from a leaf up to the root; a right child contributes a one.
    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_wpl <= '0;
        end
        if (i_cmd.leaf_capture) begin
            r_up    <= r_pq;
            r_ws    <= r_wq[WEIGHT_BITS-1:0];
            r_child <= NW'(r_s);
            r_len   <= '0;
            r_code  <= '0;
        end
        if (i_cmd.step_capture) begin
            if (r_lq != r_child) begin
                r_code <= r_code | (CODE_W'(1) << r_len);
            end
            r_len   <= r_len + 1'b1;
            r_child <= r_up;
            r_up    <= r_pq;
        end
        if (i_cmd.emit) begin
            r_wpl      <= w_tot;
            r_out_sym  <= SYM_W'(r_s - 1'b1);
            r_out_code <= r_code;
            r_out_len  <= LEN_W'(r_len);
            r_out_tot  <= w_last_sym ? w_tot : '0;
            r_out_last <= w_last_sym;
        end
    end

    assign o_stat.merges_done = (r_k == KW'({r_n, 1'b0}));
    assign o_stat.scan_done   = (r_i == r_k) && !r_pv;
    assign o_stat.up_zero     = (r_up == '0);
    assign o_stat.out_free    = !r_out_vld || i_out_ready;
    assign o_stat.last_sym    = w_last_sym;

    assign o_out_valid = r_out_vld;
    assign o_out_sym   = r_out_sym;
    assign o_out_code  = r_out_code;
    assign o_out_len   = r_out_len;
    assign o_out_total = r_out_tot;
    assign o_out_last  = r_out_last;

    `HCB_ASSERT_IMP(a_picks_distinct, i_cmd.write_a, (r_a != r_b) && (r_cnt == 2'd2))
    `HCB_ASSERT_IMP(a_merge_bound, 1'b1, r_k <= KW'({r_n, 1'b0}) || !i_cmd.write_a)
    `HCB_ASSERT_NXT(a_set_cleared, i_cmd.emit && w_last_sym, r_n == '0)
    `HCB_ASSERT_IMP(a_out_from_emit, $rose(r_out_vld), $past(i_cmd.emit))

endmodule

// ===== design/huffman_code_builder_unit.sv =====
// Huffman code builder: takes one set of symbol weights and returns one code per symbol.
// Depends on hcb_pkg, hcb_ctrl and hcb_datapath.
//
// Input stream: one weight per request on s_axis_tdata, in symbol order; s_axis_tlast
// marks the final weight and closes the set. Weights beyond MAX_SYMBOLS are dropped,
// but their tlast still closes the set. Loading accepts weights back to back.
// After the set closes, the block builds the tree: each of the n-1 merges scans the
// node store one node per cycle through its single read port. Then each symbol walks
// from its leaf to the root: it reads the leaf in S_LEAF_ISSUE and S_LEAF_CAPTURE,
// climbs a tree level per pass of S_STEP_CHECK and S_STEP_CAPTURE, and emits in S_EMIT.
// Output stream: one request per symbol, in symbol order; m_axis_tlast marks the last
// one, which also carries the weighted path length. s_axis_tready is low from the
// closing weight until the last result has entered the output register.
// When the receiver stalls, the result waits in the output register and the next walk
// holds in S_EMIT. Reset clears the set and the output register; a new set can start at once.
module huffman_code_builder_unit #(
    parameter int MAX_SYMBOLS = 32,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // weight
    input  logic [((WEIGHT_BITS+7)/8)*8-1:0]    s_axis_tdata,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // symbol_index, code_bits, code_length, weighted_total, zero fill
    output logic [hcb_pkg::OUT_DW-1:0]          m_axis_tdata,
    output logic                                m_axis_tlast
);
    import hcb_pkg::*;

    t_cmd               w_cmd;
    t_stat              w_stat;
    logic [SYM_W-1:0]   w_sym;
    logic [CODE_W-1:0]  w_code;
    logic [LEN_W-1:0]   w_len;
    logic [TOTAL_W-1:0] w_tot;

    hcb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_in_ready (s_axis_tready)
    );

    hcb_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_weight    (s_axis_tdata[WEIGHT_BITS-1:0]),
        .i_out_ready (m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_sym   (w_sym),
        .o_out_code  (w_code),
        .o_out_len   (w_len),
        .o_out_total (w_tot),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DW - SYM_W - CODE_W - LEN_W - TOTAL_W){1'b0}},
                           w_tot, w_len, w_code, w_sym};

endmodule
